FILE: hdl/mbbc_pkg.sv
// Shared constants and controller/datapath interface types for the mask crop block.
package mbbc_pkg;

  localparam int CFG_W         = 9;
  localparam int PIX_W         = 8;
  localparam int ORIGIN_W      = 8;
  localparam int SIZE_W        = 9;
  localparam int CFG_RESET_DIM = 256;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef struct packed {
    logic load;
    logic read_issue;
    logic emit_sum;
    logic emit_err;
    logic emit_pix;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic readout_ok;
  } status_t;

endpackage

FILE: hdl/mbbc_ram.sv
// Generic single-port RAM with registered read data.
module mbbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/mbbc_ctrl.sv
// Controller state machine: request decode, summary and readout sequencing.
module mbbc_ctrl import mbbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    req_type,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_LOAD) begin
            cmd.load = 1'b1;
            if (status.load_last) begin
              state_next = ST_SUM;
            end
          end else if (status.readout_ok) begin
            cmd.read_issue = 1'b1;
            state_next     = ST_READ;
          end else begin
            cmd.emit_err = 1'b1;
          end
        end
      end
      ST_SUM: begin
        cmd.emit_sum = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_READ: begin
        cmd.emit_pix = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: hdl/mbbc_datapath.sv
// Datapath: pixel store, load counters, bounding box tracking, readout addressing.
module mbbc_datapath import mbbc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [PIX_W-1:0]    pixel_value,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                result_valid,
  output logic                result_kind,
  output logic [ORIGIN_W-1:0] crop_left,
  output logic [ORIGIN_W-1:0] crop_top,
  output logic [SIZE_W-1:0]   crop_width,
  output logic [SIZE_W-1:0]   crop_height,
  output logic                mask_empty,
  output logic [PIX_W-1:0]    out_pixel,
  output logic                last_pixel,
  output logic                read_error
);

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CSIZE_W = COL_W + 1;
  localparam int RSIZE_W = ROW_W + 1;
  localparam int RST_WD  = (MAX_WIDTH < CFG_RESET_DIM) ? MAX_WIDTH : CFG_RESET_DIM;
  localparam int RST_HT  = (MAX_HEIGHT < CFG_RESET_DIM) ? MAX_HEIGHT : CFG_RESET_DIM;

  typedef enum logic [1:0] {
    PH_LOADING = 2'd0,
    PH_READOUT = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  phase_t            phase;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic [ADDR_W-1:0] load_addr;
  logic [COL_W-1:0]  load_col;
  logic [ROW_W-1:0]  load_row;
  logic [ADDR_W-1:0] row_start;
  logic              box_found;

  logic [COL_W-1:0]  box_min_col, box_max_col;
  logic [ROW_W-1:0]  box_min_row, box_max_row;
  logic [ADDR_W-1:0] box_row_base;
  logic [COL_W-1:0]  rd_col;
  logic [ROW_W-1:0]  rd_row;
  logic [ADDR_W-1:0] rd_addr, rd_row_base;
  logic              rd_last;

  logic              loading;
  logic [ADDR_W-1:0] cur_addr, cur_row_start;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic              cur_found;
  logic              at_row_end;
  logic              pix_nz;
  logic              rd_col_end, rd_row_end;
  logic [ADDR_W-1:0] w_ext, next_row_base, next_row_addr;
  logic [CSIZE_W-1:0] box_w;
  logic [RSIZE_W-1:0] box_h;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  // loads after a finished image start from the restart values
  assign loading       = (phase == PH_LOADING);
  assign cur_addr      = loading ? load_addr : '0;
  assign cur_row_start = loading ? row_start : '0;
  assign cur_col       = loading ? load_col : '0;
  assign cur_row       = loading ? load_row : '0;
  assign cur_found     = loading ? box_found : 1'b0;
  assign at_row_end    = (cur_col == last_col);
  assign pix_nz        = (pixel_value != '0);

  assign status.load_last  = at_row_end && (cur_row == last_row);
  assign status.readout_ok = (phase == PH_READOUT);

  assign rd_col_end    = (rd_col == box_max_col);
  assign rd_row_end    = (rd_row == box_max_row);
  assign w_ext         = ADDR_W'(last_col) + ADDR_W'(1);
  assign next_row_base = rd_row_base + w_ext;
  assign next_row_addr = next_row_base + ADDR_W'(box_min_col);

  assign box_w = CSIZE_W'(box_max_col) - CSIZE_W'(box_min_col) + CSIZE_W'(1);
  assign box_h = RSIZE_W'(box_max_row) - RSIZE_W'(box_min_row) + RSIZE_W'(1);

  assign ram_we   = cmd.load;
  assign ram_addr = cmd.load ? cur_addr : rd_addr;

  mbbc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(pixel_value),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LOADING;
      last_col     <= COL_W'(RST_WD - 1);
      last_row     <= ROW_W'(RST_HT - 1);
      load_addr    <= '0;
      load_col     <= '0;
      load_row     <= '0;
      row_start    <= '0;
      box_found    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_sum | cmd.emit_err | cmd.emit_pix;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            if (cfg_data == '0) begin
              last_col <= '0;
            end else if (cfg_data > MAX_WIDTH) begin
              last_col <= COL_W'(MAX_WIDTH - 1);
            end else begin
              last_col <= COL_W'(cfg_data - CFG_W'(1));
            end
          end
          REG_IMAGE_HEIGHT: begin
            if (cfg_data == '0) begin
              last_row <= '0;
            end else if (cfg_data > MAX_HEIGHT) begin
              last_row <= ROW_W'(MAX_HEIGHT - 1);
            end else begin
              last_row <= ROW_W'(cfg_data - CFG_W'(1));
            end
          end
          default: begin
          end
        endcase
        phase     <= PH_LOADING;
        load_addr <= '0;
        load_col  <= '0;
        load_row  <= '0;
        row_start <= '0;
        box_found <= 1'b0;
      end else begin
        if (cmd.load) begin
          phase     <= PH_LOADING;
          load_addr <= cur_addr + ADDR_W'(1);
          box_found <= cur_found | pix_nz;
          if (at_row_end) begin
            load_col  <= '0;
            load_row  <= cur_row + ROW_W'(1);
            row_start <= cur_addr + ADDR_W'(1);
          end else begin
            load_col  <= cur_col + COL_W'(1);
            load_row  <= cur_row;
            row_start <= cur_row_start;
          end
        end
        if (cmd.emit_sum) begin
          phase <= box_found ? PH_READOUT : PH_DONE;
        end
        if (cmd.read_issue && rd_col_end && rd_row_end) begin
          phase <= PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && pix_nz) begin
      if (!cur_found) begin
        box_min_col  <= cur_col;
        box_max_col  <= cur_col;
        box_min_row  <= cur_row;
        box_max_row  <= cur_row;
        box_row_base <= cur_row_start;
      end else begin
        if (cur_col < box_min_col) begin
          box_min_col <= cur_col;
        end
        if (cur_col > box_max_col) begin
          box_max_col <= cur_col;
        end
        box_max_row <= cur_row;
      end
    end

    if (cmd.emit_sum) begin
      rd_col      <= box_min_col;
      rd_row      <= box_min_row;
      rd_addr     <= box_row_base + ADDR_W'(box_min_col);
      rd_row_base <= box_row_base;
    end else if (cmd.read_issue) begin
      rd_last <= rd_col_end && rd_row_end;
      if (rd_col_end) begin
        rd_col      <= box_min_col;
        rd_row      <= rd_row + ROW_W'(1);
        rd_row_base <= next_row_base;
        rd_addr     <= next_row_addr;
      end else begin
        rd_col  <= rd_col + COL_W'(1);
        rd_addr <= rd_addr + ADDR_W'(1);
      end
    end

    if (cmd.emit_sum) begin
      result_kind <= KIND_SUMMARY;
      crop_left   <= box_found ? ORIGIN_W'(box_min_col) : '0;
      crop_top    <= box_found ? ORIGIN_W'(box_min_row) : '0;
      crop_width  <= box_found ? SIZE_W'(box_w) : '0;
      crop_height <= box_found ? SIZE_W'(box_h) : '0;
      mask_empty  <= !box_found;
      out_pixel   <= '0;
      last_pixel  <= 1'b0;
      read_error  <= 1'b0;
    end else if (cmd.emit_err || cmd.emit_pix) begin
      result_kind <= KIND_READOUT;
      crop_left   <= '0;
      crop_top    <= '0;
      crop_width  <= '0;
      crop_height <= '0;
      mask_empty  <= 1'b0;
      out_pixel   <= cmd.emit_pix ? ram_rdata : '0;
      last_pixel  <= cmd.emit_pix ? rd_last : 1'b0;
      read_error  <= cmd.emit_err;
    end
  end

endmodule

FILE: hdl/mask_bounding_box_crop_core.sv
// Top level of the mask bounding-box crop block.
// A load request (req_type 0) stores one pixel; the load that completes the image
// raises busy for one cycle while the summary is formed, and the summary shows
// on the result ports the cycle after that. A readout request (req_type 1) uses
// the registered read of the single-port pixel store: busy is high for one cycle
// and the pixel shows the cycle after. A readout with nothing to read is not busy
// and its error result shows the next cycle. Each result is on the ports for one
// cycle with result_valid high and cannot be held off, so it must be captured when
// it appears. A register write restarts loading; stored pixels are kept.
module mask_bounding_box_crop_core import mbbc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [PIX_W-1:0]    pixel_value,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                result_valid,
  output logic                result_kind,
  output logic [ORIGIN_W-1:0] crop_left,
  output logic [ORIGIN_W-1:0] crop_top,
  output logic [SIZE_W-1:0]   crop_width,
  output logic [SIZE_W-1:0]   crop_height,
  output logic                mask_empty,
  output logic [PIX_W-1:0]    out_pixel,
  output logic                last_pixel,
  output logic                read_error
);

  cmd_t    cmd;
  status_t status;

  mbbc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  mbbc_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (pixel_value),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result_kind (result_kind),
    .crop_left   (crop_left),
    .crop_top    (crop_top),
    .crop_width  (crop_width),
    .crop_height (crop_height),
    .mask_empty  (mask_empty),
    .out_pixel   (out_pixel),
    .last_pixel  (last_pixel),
    .read_error  (read_error)
  );

endmodule

FILE: hdl/mbbc_checker.sv
// Port-level assertion checker for the mask crop block, bound to the top level.
module mbbc_checker import mbbc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              req_type,
  input logic              result_valid,
  input logic              result_kind,
  input logic [SIZE_W-1:0] crop_width,
  input logic              mask_empty,
  input logic [PIX_W-1:0]  out_pixel,
  input logic              last_pixel,
  input logic              read_error
);

  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> result_valid)
    else $error("busy cycle not followed by a result transfer");

  a_read_response: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_READ) |=> (result_valid != busy))
    else $error("readout transfer got neither error result nor store access");

  a_summary_size: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == KIND_SUMMARY) |-> (mask_empty == (crop_width == '0)))
    else $error("summary size disagrees with empty flag");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == KIND_READOUT && read_error)
      |-> (out_pixel == '0 && !last_pixel))
    else $error("error readout carries pixel data");

endmodule

bind mask_bounding_box_crop_core mbbc_checker u_mbbc_checker (.*);
